// File: sv/swp_pkg.sv
// ----------------------------------------------------------------------------
// swp_pkg: shared types and constants for the source whitespace packer
// Holds character codes, register map, phase encoding and the queue push item.
// ----------------------------------------------------------------------------
package swp_pkg;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Line break code = CODE_BASE + indentation count
    localparam logic [7:0] CODE_BASE = 8'd10;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    // Configuration reset values
    localparam logic [4:0] TAB_WIDTH_RST = 5'd8;
    localparam logic [6:0] RUN_LIMIT_RST = 7'd30;

    // Output queue depth default (at least two slots)
    localparam int FIFO_DEPTH_DEF = 4;

    // Register map, indexed by paddr[2]
    typedef enum logic {
        REG_TAB_WIDTH = 1'b0,
        REG_RUN_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SEMI  = 3'd1,
        PH_HOLD  = 3'd2,
        PH_PART  = 3'd3,
        PH_COUNT = 3'd4
    } t_phase;

    // Up to two result items produced by one input item, in order
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] char0;
        logic       last0;
        logic [7:0] char1;
        logic       last1;
    } t_push;

    // Line break code byte for a given count and semicolon mark
    function automatic logic [7:0] swp_code(input logic [6:0] cnt, input logic semi);
        logic [7:0] sum;
        sum = CODE_BASE + {1'b0, cnt};
        return sum | (semi ? HIGH_BIT : 8'h00);
    endfunction

endpackage

// File: sv/source_whitespace_packer.sv
// ----------------------------------------------------------------------------
// source_whitespace_packer: whitespace compressor for program text
// One byte in per cycle while the result queue has room; line breaks and indentation fold into code bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle on the s_axis side and sustains that
// rate: each byte passes an input register, combinational packing logic and a
// small result queue, which registers the results it hands out. A byte yields
// zero, one or two result items; two come only when a
// pending byte or line break meets the final byte of a stream (tlast) and is
// flushed. s_axis_tready falls while a byte waits in the input register and
// fewer than two queue slots are free, so a stalled m_axis side holds the
// input back after the queue fills; with the output draining every cycle no
// stall arises. A CR or LF (with its opposite
// partner absorbed) becomes the code 10 + indentation, spaces adding one and
// tabs adding tab_width while the count is below run_limit; a ';' right before
// the break sets bit 7 of the code. A byte followed by a space is sent with
// bit 7 set and the space dropped. Registers: tab_width at 0x0 (5 bits,
// reset 8), run_limit at 0x4 (7 bits, reset 30); write them only while idle.
// ----------------------------------------------------------------------------
module source_whitespace_packer #(
    parameter int FIFO_DEPTH = swp_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tlast,   // is_last
    // result byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,   // out_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]     r_tab_width;
    logic [6:0]     r_run_limit;
    logic           r_in_valid;
    logic [7:0]     r_in_char;
    logic           r_in_last;
    logic           step;
    logic           room;
    logic           cfg_wr;
    swp_pkg::t_push push;
    swp_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = swp_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // read back the addressed register
    always_comb begin
        unique case (reg_idx)
            swp_pkg::REG_TAB_WIDTH: prdata = {27'd0, r_tab_width};
            swp_pkg::REG_RUN_LIMIT: prdata = {25'd0, r_run_limit};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= swp_pkg::TAB_WIDTH_RST;
            r_run_limit <= swp_pkg::RUN_LIMIT_RST;
        end else if (cfg_wr) begin
            if (reg_idx == swp_pkg::REG_TAB_WIDTH) begin
                r_tab_width <= pwdata[4:0];
            end else begin
                r_run_limit <= pwdata[6:0];
            end
        end
    end

    // step the held byte only when the queue can take two results
    assign step          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    swp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_tab_width (r_tab_width),
        .i_run_limit (r_run_limit),
        .o_push      (push)
    );

    swp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// File: sv/swp_fifo.sv
// ----------------------------------------------------------------------------
// swp_fifo: result item queue
// Takes up to two items per cycle, hands out one; room flags two free slots.
// ----------------------------------------------------------------------------
module swp_fifo #(
    parameter int DEPTH = swp_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  swp_pkg::t_push i_push,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_char,
    output logic          o_last
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [8:0]    r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wr_nxt;
    logic [PW-1:0] wr_nxt2;
    logic [PW-1:0] rd_nxt;
    logic          pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign wr_nxt  = inc(r_wr);
    assign wr_nxt2 = inc(wr_nxt);
    assign rd_nxt  = inc(r_rd);
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_char  = r_mem[r_rd][8:1];
    assign o_last  = r_mem[r_rd][0];

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= {i_push.char0, i_push.last0};
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_nxt] <= {i_push.char1, i_push.last1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            case (i_push.num)
                2'd1:    r_wr <= wr_nxt;
                2'd2:    r_wr <= wr_nxt2;
                default: r_wr <= r_wr;
            endcase
            if (pop) begin
                r_rd <= rd_nxt;
            end
            r_count <= r_count + CW'(i_push.num) - CW'(pop);
        end
    end

endmodule

// File: sv/swp_core.sv
// ----------------------------------------------------------------------------
// swp_core: packing state machine
// Steps one registered byte per cycle while i_step is high and emits up to two result items.
// ----------------------------------------------------------------------------
module swp_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic [4:0]    i_tab_width,
    input  logic [6:0]    i_run_limit,
    output swp_pkg::t_push o_push
);

    swp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic            r_semi, n_semi;
    logic            r_nk, n_nk;
    logic [6:0]      r_cnt, n_cnt;

    swp_pkg::t_phase ph;
    logic [7:0]      held;
    logic            semi;
    logic            nk;
    logic [6:0]      cnt;
    logic            e0_v, f_v;
    logic [7:0]      e0_c, f_c;
    logic            is_brk, is_cr, is_sp, is_tab;
    logic [7:0]      cnt_sum;
    logic            do_fresh;

    assign is_cr  = (i_char == swp_pkg::CH_CR);
    assign is_brk = is_cr || (i_char == swp_pkg::CH_LF);
    assign is_sp  = (i_char == swp_pkg::CH_SPACE);
    assign is_tab = (i_char == swp_pkg::CH_TAB);
    assign cnt_sum = {1'b0, r_cnt} + (is_sp ? 8'd1 : {3'b000, i_tab_width});

    always_comb begin
        ph       = r_phase;
        held     = r_held;
        semi     = r_semi;
        nk       = r_nk;
        cnt      = r_cnt;
        e0_v     = 1'b0;
        e0_c     = 8'h00;
        do_fresh = 1'b0;
        unique case (r_phase)
            swp_pkg::PH_SEMI: begin
                if (is_brk) begin
                    ph   = swp_pkg::PH_PART;
                    semi = 1'b1;
                    nk   = is_cr;
                    cnt  = '0;
                end else begin
                    e0_v = 1'b1;
                    e0_c = swp_pkg::CH_SEMI;
                    ph   = swp_pkg::PH_HOLD;
                    held = i_char;
                    semi = 1'b0;
                end
            end
            swp_pkg::PH_HOLD: begin
                e0_v = 1'b1;
                if (is_sp) begin
                    e0_c = r_held | swp_pkg::HIGH_BIT;
                    ph   = swp_pkg::PH_IDLE;
                    held = '0;
                    semi = 1'b0;
                    nk   = 1'b0;
                    cnt  = '0;
                end else begin
                    e0_c     = r_held;
                    held     = '0;
                    do_fresh = 1'b1;
                end
            end
            swp_pkg::PH_PART, swp_pkg::PH_COUNT: begin
                if (r_phase == swp_pkg::PH_PART && is_brk && is_cr != r_nk) begin
                    // absorb the CR/LF partner
                    ph = swp_pkg::PH_COUNT;
                end else if (r_cnt < i_run_limit && (is_sp || is_tab)) begin
                    cnt = (cnt_sum > {1'b0, swp_pkg::COUNT_MAX}) ? swp_pkg::COUNT_MAX
                                                                 : cnt_sum[6:0];
                    ph  = swp_pkg::PH_COUNT;
                end else begin
                    e0_v     = 1'b1;
                    e0_c     = swp_pkg::swp_code(r_cnt, r_semi);
                    semi     = 1'b0;
                    cnt      = '0;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // start fresh from this byte
        if (do_fresh) begin
            if (i_char == swp_pkg::CH_SEMI) begin
                ph   = swp_pkg::PH_SEMI;
                semi = 1'b1;
            end else if (is_brk) begin
                ph   = swp_pkg::PH_PART;
                semi = 1'b0;
                nk   = is_cr;
                cnt  = '0;
            end else begin
                ph   = swp_pkg::PH_HOLD;
                held = i_char;
                semi = 1'b0;
            end
        end

        // flush on the final byte
        f_v = 1'b0;
        f_c = 8'h00;
        if (i_last) begin
            unique case (ph) inside
                swp_pkg::PH_SEMI: begin
                    f_v = 1'b1;
                    f_c = swp_pkg::CH_SEMI;
                end
                swp_pkg::PH_HOLD: begin
                    f_v = 1'b1;
                    f_c = held;
                end
                swp_pkg::PH_PART, swp_pkg::PH_COUNT: begin
                    f_v = 1'b1;
                    f_c = swp_pkg::swp_code(cnt, semi);
                end
                default: begin
                    f_v = 1'b0;
                end
            endcase
        end

        n_phase = ph;
        n_held  = held;
        n_semi  = semi;
        n_nk    = nk;
        n_cnt   = cnt;
        if (i_last) begin
            n_phase = swp_pkg::PH_IDLE;
            n_held  = '0;
            n_semi  = 1'b0;
            n_nk    = 1'b0;
            n_cnt   = '0;
        end

        o_push.num   = i_step ? (2'(e0_v) + 2'(f_v)) : 2'd0;
        o_push.char0 = e0_v ? e0_c : f_c;
        o_push.last0 = i_last && !(e0_v && f_v);
        o_push.char1 = f_c;
        o_push.last1 = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swp_pkg::PH_IDLE;
            r_held  <= '0;
            r_semi  <= 1'b0;
            r_nk    <= 1'b0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_semi  <= n_semi;
            r_nk    <= n_nk;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: sv/swp_checker.sv
// ----------------------------------------------------------------------------
// swp_checker: port-level checks for the source whitespace packer
// Watches reset behavior, output stalls and register write-back.
// ----------------------------------------------------------------------------
module swp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // nothing queued and input open right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not idle after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // tab_width reads back what was written
    a_tab_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
            paddr[2] || prdata == {27'd0, $past(pwdata[4:0])})
        else $error("tab_width write-back mismatch");

    // run_limit reads back what was written
    a_run_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] |=>
            !paddr[2] || prdata == {25'd0, $past(pwdata[6:0])})
        else $error("run_limit write-back mismatch");

endmodule

bind source_whitespace_packer swp_checker u_swp_checker (.*);
